@@ hdl/dwsp_pkg.sv @@
package dwsp_pkg;

    // pulse counter width, the rest of the datapath follows from it (8..32)
    localparam int COUNT_WIDTH = 16;

    localparam int GOAL_W = 6;
    localparam int DUTY_W = 7;
    localparam int DIR_W  = 8;
    localparam int SPEED_W = 8;
    localparam int PGAIN_W = 8;
    localparam int DGAIN_W = 4;

    // signed error, derivative and Q4.4 accumulator widths
    localparam int ERR_W = COUNT_WIDTH + 1;
    localparam int DER_W = COUNT_WIDTH + 2;
    localparam int ACC_W = COUNT_WIDTH + 12;

    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [PGAIN_W-1:0] PGAIN_RESET = PGAIN_W'(24);
    localparam logic [DGAIN_W-1:0] DGAIN_RESET = DGAIN_W'(1);

    // speed*56/375 as (speed * ceil(56*2^22/375)) >> 22, exact for 8-bit speeds
    localparam int SPEED_SHIFT = 22;
    localparam int SPEED_RECIP = 626350;
    localparam int SPEED_PROD_W = SPEED_W + 20;

    typedef enum logic [1:0] {
        REQ_PULSE_LEFT  = 2'd0,
        REQ_PULSE_RIGHT = 2'd1,
        REQ_TICK        = 2'd2,
        REQ_COMMAND     = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic [PGAIN_W-1:0] prop_gain;
        logic [DGAIN_W-1:0] deriv_gain;
    } pd_gains_t;

    function automatic logic [GOAL_W-1:0] speed_to_goal(input logic [SPEED_W-1:0] speed);
        logic [SPEED_PROD_W-1:0] prod;
        prod = SPEED_PROD_W'(speed) * SPEED_PROD_W'(SPEED_RECIP);
        return prod[SPEED_SHIFT +: GOAL_W];
    endfunction

endpackage

@@ hdl/dwsp_cfg.sv @@
module dwsp_cfg
    import dwsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output pd_gains_t   gains
);

    logic [PGAIN_W-1:0] prop_gain_reg;
    logic [DGAIN_W-1:0] deriv_gain_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PGAIN_RESET;
            deriv_gain_reg <= DGAIN_RESET;
        end
        else if (wr_en)
        begin
            // register index sits at paddr[2]
            if (!paddr[2])
            begin
                prop_gain_reg <= pwdata[PGAIN_W-1:0];
            end
            else
            begin
                deriv_gain_reg <= pwdata[DGAIN_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (!paddr[2])
        begin
            prdata = 32'(prop_gain_reg);
        end
        else
        begin
            prdata = 32'(deriv_gain_reg);
        end
    end

    assign gains.prop_gain  = prop_gain_reg;
    assign gains.deriv_gain = deriv_gain_reg;

endmodule

@@ hdl/dwsp_pd.sv @@
module dwsp_pd
    import dwsp_pkg::*;
(
    input  pd_gains_t                gains,
    input  logic [DUTY_W-1:0]        duty,
    input  logic signed [ERR_W-1:0]  prev_err,
    input  logic [COUNT_WIDTH-1:0]   count,
    input  logic [GOAL_W-1:0]        goal,
    output logic [DUTY_W-1:0]        duty_next,
    output logic signed [ERR_W-1:0]  err
);

    logic signed [DER_W-1:0]   deriv;
    logic signed [ERR_W+8:0]   p_term;
    logic signed [DER_W+4:0]   d_term;
    logic signed [ACC_W-1:0]   acc;
    logic [ACC_W-5:0]          quot;

    always_comb
    begin
        err    = $signed({{(ERR_W-GOAL_W){1'b0}}, goal}) - $signed({1'b0, count});
        deriv  = $signed({err[ERR_W-1], err}) - $signed({prev_err[ERR_W-1], prev_err});
        p_term = $signed({1'b0, gains.prop_gain}) * err;
        d_term = $signed({1'b0, gains.deriv_gain}) * deriv;
        // Q4.4 sum: 16*duty + Kp*err + 16*Kd*deriv
        acc    = $signed(ACC_W'({duty, 4'b0000})) + ACC_W'(p_term)
               + (ACC_W'(d_term) <<< 4);
        quot   = acc[ACC_W-1:4];

        if (acc[ACC_W-1])
        begin
            duty_next = '0;
        end
        else if (quot > (ACC_W-4)'(DUTY_MAX))
        begin
            duty_next = DUTY_MAX;
        end
        else
        begin
            duty_next = quot[DUTY_W-1:0];
        end
    end

endmodule

@@ hdl/dual_wheel_speed_pd_loop_core.sv @@
// two-wheel incremental pd speed loop
//
// input stream (s_*): one transaction per event. s_tuser carries the kind
// (left pulse, right pulse, sampling tick, command); s_tdata carries the
// speed and direction bytes, looked at only by commands.
// output stream (m_*): exactly one transaction per input transaction, in order,
// holding both duties and both latched direction bytes after that event.
// config (apb): prop_gain (q4.4) at 0x0, deriv_gain at 0x4; the user must write
// them only while the stream is idle, not enforced by the block; pready is tied
// high, reads return the register.
// an input transaction passes through an input register, then one pass of
// counter, goal and pd logic into the result register. throughput is one
// transaction per cycle, set by that single pass, while m_tready is high.
// when m_tready is low the result register holds; one more item may wait
// in the input register, after that s_tready drops until the result is taken.
// reset clears counters, goals, duties, errors and directions, empties both
// stages and loads the gains with 1.5 and 1.
module dual_wheel_speed_pd_loop_core
    import dwsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // speed_left, dir_left, speed_right, dir_right
    input  logic [1:0]  s_tuser,   // req_type
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // duty_left, duty_right, dir_left_out,
                                   // dir_right_out, two zero bits
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    pd_gains_t gains;

    // input stage
    logic               in_valid_reg;
    req_kind_t          kind_reg;
    logic [SPEED_W-1:0] speed_left_reg;
    logic [DIR_W-1:0]   dir_left_reg;
    logic [SPEED_W-1:0] speed_right_reg;
    logic [DIR_W-1:0]   dir_right_reg;

    // loop state
    logic [COUNT_WIDTH-1:0]   pulses_left_reg,  pulses_left_next;
    logic [COUNT_WIDTH-1:0]   pulses_right_reg, pulses_right_next;
    logic [GOAL_W-1:0]        goal_left_reg,    goal_left_next;
    logic [GOAL_W-1:0]        goal_right_reg,   goal_right_next;
    logic [DUTY_W-1:0]        drive_left_reg,   drive_left_next;
    logic [DUTY_W-1:0]        drive_right_reg,  drive_right_next;
    logic signed [ERR_W-1:0]  prev_err_left_reg,  prev_err_left_next;
    logic signed [ERR_W-1:0]  prev_err_right_reg, prev_err_right_next;
    logic [DIR_W-1:0]         heading_left_reg,  heading_left_next;
    logic [DIR_W-1:0]         heading_right_reg, heading_right_next;

    // pd results for a tick
    logic [DUTY_W-1:0]        pd_duty_left, pd_duty_right;
    logic signed [ERR_W-1:0]  pd_err_left, pd_err_right;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_data_reg;

    logic advance;   // result register free to take the input stage
    logic fire;      // input stage item processed this cycle

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    dwsp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    dwsp_pd u_pd_left (
        .gains     (gains),
        .duty      (drive_left_reg),
        .prev_err  (prev_err_left_reg),
        .count     (pulses_left_reg),
        .goal      (goal_left_reg),
        .duty_next (pd_duty_left),
        .err       (pd_err_left)
    );

    // right wheel keeps its own previous error
    dwsp_pd u_pd_right (
        .gains     (gains),
        .duty      (drive_right_reg),
        .prev_err  (prev_err_right_reg),
        .count     (pulses_right_reg),
        .goal      (goal_right_reg),
        .duty_next (pd_duty_right),
        .err       (pd_err_right)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            kind_reg        <= req_kind_t'(s_tuser);
            speed_left_reg  <= s_tdata[7:0];
            dir_left_reg    <= s_tdata[15:8];
            speed_right_reg <= s_tdata[23:16];
            dir_right_reg   <= s_tdata[31:24];
        end
    end

    // next state for the item in the input stage
    always_comb
    begin
        pulses_left_next    = pulses_left_reg;
        pulses_right_next   = pulses_right_reg;
        goal_left_next      = goal_left_reg;
        goal_right_next     = goal_right_reg;
        drive_left_next     = drive_left_reg;
        drive_right_next    = drive_right_reg;
        prev_err_left_next  = prev_err_left_reg;
        prev_err_right_next = prev_err_right_reg;
        heading_left_next   = heading_left_reg;
        heading_right_next  = heading_right_reg;

        unique case (kind_reg)
            REQ_PULSE_LEFT:
            begin
                // saturating count
                if (pulses_left_reg != COUNT_MAX)
                begin
                    pulses_left_next = pulses_left_reg + 1'b1;
                end
            end
            REQ_PULSE_RIGHT:
            begin
                if (pulses_right_reg != COUNT_MAX)
                begin
                    pulses_right_next = pulses_right_reg + 1'b1;
                end
            end
            REQ_TICK:
            begin
                pulses_left_next    = '0;
                pulses_right_next   = '0;
                drive_left_next     = pd_duty_left;
                drive_right_next    = pd_duty_right;
                prev_err_left_next  = pd_err_left;
                prev_err_right_next = pd_err_right;
            end
            REQ_COMMAND:
            begin
                goal_left_next     = speed_to_goal(speed_left_reg);
                goal_right_next    = speed_to_goal(speed_right_reg);
                heading_left_next  = dir_left_reg;
                heading_right_next = dir_right_reg;
            end
            default:
            begin
            end
        endcase
    end

    // loop state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulses_left_reg    <= '0;
            pulses_right_reg   <= '0;
            goal_left_reg      <= '0;
            goal_right_reg     <= '0;
            drive_left_reg     <= '0;
            drive_right_reg    <= '0;
            prev_err_left_reg  <= '0;
            prev_err_right_reg <= '0;
            heading_left_reg   <= '0;
            heading_right_reg  <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pulses_left_reg    <= pulses_left_next;
                pulses_right_reg   <= pulses_right_next;
                goal_left_reg      <= goal_left_next;
                goal_right_reg     <= goal_right_next;
                drive_left_reg     <= drive_left_next;
                drive_right_reg    <= drive_right_next;
                prev_err_left_reg  <= prev_err_left_next;
                prev_err_right_reg <= prev_err_right_next;
                heading_left_reg   <= heading_left_next;
                heading_right_reg  <= heading_right_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= {2'b00, heading_right_next, heading_left_next,
                             drive_right_next, drive_left_next};
        end
    end

endmodule

@@ sim/tb_dual_wheel_speed_pd_loop_core.sv @@
`timescale 1ns / 1ps

module tb_dual_wheel_speed_pd_loop_core;

    import dwsp_pkg::*;

    // register indexes, byte address is 4*index
    localparam int REG_PROP_GAIN  = 0;
    localparam int REG_DERIV_GAIN = 1;

    localparam int RANDOM_ITEMS = 900;
    localparam int PHASES       = 6;

    // one output transaction, field by field
    typedef struct packed {
        logic [DUTY_W-1:0] duty_left;
        logic [DUTY_W-1:0] duty_right;
        logic [DIR_W-1:0]  dir_left;
        logic [DIR_W-1:0]  dir_right;
    } wheel_out_t;

    // one row of the directed table; fixed rows carry a hand-typed result
    typedef struct {
        req_kind_t   kind;
        logic [31:0] data;
        bit          fixed;
        wheel_out_t  want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // speed_left, dir_left, speed_right, dir_right
    logic [1:0]  s_tuser;   // req_type
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // duty_left, duty_right, dir_left_out, dir_right_out, pad
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dual_wheel_speed_pd_loop_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 12 ns period
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // speed loop predictor: own copy of gains, counters, goals, duties
    // ------------------------------------------------------------------
    logic [PGAIN_W-1:0]      kp_q44;
    logic [DGAIN_W-1:0]      kd_gain;
    logic [COUNT_WIDTH-1:0]  count_l, count_r;
    logic [GOAL_W-1:0]       goal_l, goal_r;
    logic [DUTY_W-1:0]       duty_l, duty_r;
    logic signed [ERR_W-1:0] last_err_l, last_err_r;
    logic [DIR_W-1:0]        head_l, head_r;

    wheel_out_t drive_expect_q[$];
    int         error_count;
    bit         idle_on;     // random gaps on both sides when set
    int         items_sent;

    // incremental pd step in q4.4, clamped to 0..100
    function automatic logic [DUTY_W-1:0] pd_next_duty(input logic [DUTY_W-1:0] duty,
                                                        input longint err,
                                                        input logic signed [ERR_W-1:0] prev);
        longint acc;
        acc = 16 * longint'(duty) + longint'(kp_q44) * err
            + 16 * longint'(kd_gain) * (err - longint'(prev));
        if (acc < 0)
            return '0;
        else if ((acc >>> 4) > 100)
            return DUTY_MAX;
        else
            return DUTY_W'(acc >>> 4);
    endfunction

    // target pulses per tick from a speed byte
    function automatic logic [GOAL_W-1:0] goal_of(input logic [SPEED_W-1:0] speed);
        int unsigned g;
        g = (int'(speed) * 56) / 375;
        return GOAL_W'(g);
    endfunction

    // apply one accepted event to the predictor, return the result it shows
    function automatic wheel_out_t apply_event(input req_kind_t kind, input logic [31:0] data);
        longint     err_l, err_r;
        wheel_out_t res;
        case (kind)
            REQ_PULSE_LEFT:
                if (count_l != COUNT_MAX) count_l = count_l + 1'b1;
            REQ_PULSE_RIGHT:
                if (count_r != COUNT_MAX) count_r = count_r + 1'b1;
            REQ_TICK: begin
                err_l = longint'(goal_l) - longint'(count_l);
                err_r = longint'(goal_r) - longint'(count_r);
                count_l = '0;
                count_r = '0;
                duty_l = pd_next_duty(duty_l, err_l, last_err_l);
                duty_r = pd_next_duty(duty_r, err_r, last_err_r);
                // each wheel keeps its own previous error
                last_err_l = ERR_W'(err_l);
                last_err_r = ERR_W'(err_r);
            end
            default: begin
                goal_l = goal_of(data[7:0]);
                head_l = data[15:8];
                goal_r = goal_of(data[23:16]);
                head_r = data[31:24];
            end
        endcase
        res.duty_left  = duty_l;
        res.duty_right = duty_r;
        res.dir_left   = head_l;
        res.dir_right  = head_r;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // input side driver
    // ------------------------------------------------------------------

    // one input transaction; the predictor runs on the accepting edge
    task automatic send_event(input req_kind_t kind, input logic [31:0] data,
                              input bit fixed, input wheel_out_t want);
        int         gap;
        wheel_out_t got;
        @(negedge clk);
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge clk); while (!s_tready);
        got = apply_event(kind, data);
        // a typed row cross-checks the predictor as well as the block
        if (fixed && (got !== want))
        begin
            $display("%0t: predictor row mismatch, expected %h, actual %h",
                     $time, want, got);
            error_count++;
        end
        drive_expect_q.push_back(fixed ? want : got);
        items_sent++;
    endtask

    task automatic send_plain(input req_kind_t kind, input logic [31:0] data);
        send_event(kind, data, 1'b0, '0);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // config port: write, then read back through the same selection
    // ------------------------------------------------------------------
    task automatic cfg_write(input int index, input logic [31:0] value);
        logic [31:0] want_rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(index * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // bits above the register width are dropped
        if (index == REG_PROP_GAIN)
        begin
            kp_q44  = value[PGAIN_W-1:0];
            want_rd = 32'(kp_q44);
        end
        else
        begin
            kd_gain = value[DGAIN_W-1:0];
            want_rd = 32'(kd_gain);
        end
        // read access follows directly, psel stays high
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want_rd)
        begin
            $display("%0t: readback of register %0d, expected %0h, actual %0h",
                     $time, index, want_rd, prdata);
            error_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // output side: random stall, then compare against the oldest expectation
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        wheel_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (drive_expect_q.size() == 0)
            begin
                $display("%0t: unexpected output transaction %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = drive_expect_q.pop_front();
                check_field("duty_left",     32'(want.duty_left),  32'(m_tdata[6:0]));
                check_field("duty_right",    32'(want.duty_right), 32'(m_tdata[13:7]));
                check_field("dir_left_out",  32'(want.dir_left),   32'(m_tdata[21:14]));
                check_field("dir_right_out", 32'(want.dir_right),  32'(m_tdata[29:22]));
                check_field("pad bits",      32'd0,                32'(m_tdata[31:30]));
            end
        end
    end

    // ------------------------------------------------------------------
    // random traffic: mostly well-formed periods of command, pulses, tick
    // ------------------------------------------------------------------
    function automatic int pulses_near(input logic [GOAL_W-1:0] goal);
        int n;
        if ($urandom_range(0, 5) == 0)
            return $urandom_range(0, 45);
        n = int'(goal) + $urandom_range(0, 8) - 4;
        return (n < 0) ? 0 : n;
    endfunction

    task automatic run_periods(input int n_items);
        int          target;
        int          nl, nr;
        logic [31:0] cmd;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            // occasional stretches with no idling at all
            idle_on = ($urandom_range(0, 5) != 0);
            if ($urandom_range(0, 3) == 0)
            begin
                cmd = $urandom();
                // mostly low speeds so a period stays short
                if ($urandom_range(0, 7) != 0) cmd[7:0]   = $urandom_range(0, 80);
                if ($urandom_range(0, 7) != 0) cmd[23:16] = $urandom_range(0, 80);
                // mostly legal direction codes, sometimes unknown ones
                if ($urandom_range(0, 5) != 0) cmd[15:8]  = $urandom_range(0, 2);
                if ($urandom_range(0, 5) != 0) cmd[31:24] = $urandom_range(0, 2);
                send_plain(REQ_COMMAND, cmd);
            end
            nl = pulses_near(goal_l);
            nr = pulses_near(goal_r);
            while (nl + nr > 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_plain(req_kind_t'($urandom_range(0, 3)), $urandom());
                else if (nr == 0 || (nl > 0 && $urandom_range(0, 1) == 0))
                begin
                    send_plain(REQ_PULSE_LEFT, $urandom());
                    nl--;
                end
                else
                begin
                    send_plain(REQ_PULSE_RIGHT, $urandom());
                    nr--;
                end
            end
            send_plain(REQ_TICK, $urandom());
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    stim_row_t dir_rows [18];

    initial
    begin
        logic [PGAIN_W-1:0] pg;
        logic [DGAIN_W-1:0] dg;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_PULSE_LEFT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        rst_n    = 1'b0;

        // predictor reset state
        kp_q44     = PGAIN_RESET;
        kd_gain    = DGAIN_RESET;
        count_l    = '0;
        count_r    = '0;
        goal_l     = '0;
        goal_r     = '0;
        duty_l     = '0;
        duty_r     = '0;
        last_err_l = '0;
        last_err_r = '0;
        head_l     = '0;
        head_r     = '0;
        error_count = 0;
        items_sent  = 0;
        idle_on     = 1'b1;

        // directed table, run with the reset gains
        dir_rows = '{
            // straight after reset everything reads zero
            '{REQ_PULSE_LEFT,  32'h0000_0000, 1'b1, '{7'd0, 7'd0, 8'd0, 8'd0}},
            // speed bytes on a pulse are ignored
            '{REQ_PULSE_RIGHT, 32'hFFFF_FFFF, 1'b1, '{7'd0, 7'd0, 8'd0, 8'd0}},
            // zero goal with a count of one drives below zero, clamps at 0
            '{REQ_TICK,        32'h0000_0000, 1'b1, '{7'd0, 7'd0, 8'd0, 8'd0}},
            // full speed left, stop right; directions latch at once
            '{REQ_COMMAND,     32'h0200_01FF, 1'b1, '{7'd0, 7'd0, 8'd1, 8'd2}},
            '{REQ_TICK,        32'h0000_0000, 1'b0, '0},
            // left runs into the upper clamp
            '{REQ_TICK,        32'hA5A5_A5A5, 1'b0, '0},
            // unknown direction bytes pass through unchanged
            '{REQ_COMMAND,     32'hFFFF_7F00, 1'b0, '0},
            '{REQ_PULSE_LEFT,  32'h5A5A_5A5A, 1'b0, '0},
            '{REQ_PULSE_LEFT,  32'h0000_0000, 1'b0, '0},
            '{REQ_PULSE_RIGHT, 32'h0000_0000, 1'b0, '0},
            '{REQ_TICK,        32'h0000_0000, 1'b0, '0},
            '{REQ_TICK,        32'h0000_0000, 1'b0, '0},
            // stop command, both goals fall to zero
            '{REQ_COMMAND,     32'h0000_0000, 1'b0, '0},
            '{REQ_TICK,        32'h0000_0000, 1'b0, '0},
            '{REQ_TICK,        32'h0000_0000, 1'b0, '0},
            // both wheels at full speed, backward and forward
            '{REQ_COMMAND,     32'h01FF_02FF, 1'b0, '0},
            '{REQ_TICK,        32'hFFFF_FFFF, 1'b0, '0},
            '{REQ_TICK,        32'h0000_0000, 1'b0, '0}
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_event(dir_rows[i].kind, dir_rows[i].data, dir_rows[i].fixed,
                       dir_rows[i].want);
        run_periods(RANDOM_ITEMS / (PHASES + 1));

        // gain settings, extremes first; each change only with the stream empty
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin pg = '0;   dg = '0;   end
                1:       begin pg = '1;   dg = '1;   end
                3:       begin pg = 8'd8; dg = '1;   end
                5:       begin pg = PGAIN_RESET; dg = DGAIN_RESET; end
                default: begin pg = $urandom(); dg = $urandom(); end
            endcase
            drain_stream();
            // random upper bits must be dropped by the register
            cfg_write(REG_PROP_GAIN,  {24'($urandom_range(0, 32'hFF_FFFF)), pg});
            cfg_write(REG_DERIV_GAIN, {28'($urandom_range(0, 32'hFFF_FFFF)), dg});
            run_periods(RANDOM_ITEMS / (PHASES + 1));
        end

        // long burst against a zero goal, no idling
        idle_on = 1'b0;
        send_plain(REQ_COMMAND, 32'h0100_0100);
        for (int n = 0; n < 45; n++)
        begin
            send_plain(REQ_PULSE_LEFT, 32'h0);
            send_plain(REQ_PULSE_RIGHT, 32'h0);
        end
        // large negative error, then full speed gives a large derivative the other way
        send_plain(REQ_TICK, 32'h0);
        send_plain(REQ_COMMAND, 32'h01FF_01FF);
        send_plain(REQ_TICK, 32'h0);
        idle_on = 1'b1;
        run_periods(40);

        drain_stream();
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("** dual_wheel_speed_pd_loop_core: PASSED **");
        else
            $display("** dual_wheel_speed_pd_loop_core: FAILED **");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #30_000_000;
        $display("** dual_wheel_speed_pd_loop_core: FAILED **");
        $finish;
    end

endmodule
